// File: src/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// shared sizes, command codes, per-stack operation codes and the structs
// passed between the front end, the back end and the two stack units
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMD_W     = 4;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [CMD_W-1:0]            cmd_t;

  localparam cmd_t CMD_LOAD  = 4'd0;
  localparam cmd_t CMD_SA    = 4'd1;
  localparam cmd_t CMD_SB    = 4'd2;
  localparam cmd_t CMD_SS    = 4'd3;
  localparam cmd_t CMD_PA    = 4'd4;
  localparam cmd_t CMD_PB    = 4'd5;
  localparam cmd_t CMD_RA    = 4'd6;
  localparam cmd_t CMD_RB    = 4'd7;
  localparam cmd_t CMD_RR    = 4'd8;
  localparam cmd_t CMD_RRA   = 4'd9;
  localparam cmd_t CMD_RRB   = 4'd10;
  localparam cmd_t CMD_RRR   = 4'd11;
  localparam cmd_t CMD_CLEAR = 4'd12;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_PUSH,
    SOP_POP,
    SOP_SWAP,
    SOP_ROT,
    SOP_RROT,
    SOP_CLEAR
  } stk_op_t;

  typedef struct packed {
    stk_op_t op_a;
    stk_op_t op_b;
    logic    move;
    word_t   value;
  } dec_t;

  typedef struct packed {
    logic    go;
    logic    fin;
    stk_op_t op;
  } stk_ctl_t;

  // ring position of item k above the bottom
  function automatic addr_t slot_of(addr_t base, addr_t k);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (ADDR_W + 1)'(DEPTH)) begin
      s = s - (ADDR_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// File: src/dual_stack_rotate_engine.sv
// ----------------------------------------------------------------------------
// dual_stack_rotate_engine
// two bounded ring stacks of signed words driven by a command stream
// ----------------------------------------------------------------------------
// request channel: req_valid / req_stall with cmd and load_value; a request
//   is taken at a clock edge with req_valid high and req_stall low
// response channel: rsp_valid / rsp_stall with top_a, top_b, count_a,
//   count_b and fault; exactly one response per request, in order
// a request reaching an empty queue goes through the queue entry, the back
//   end's S_RUN and S_FIN states and the response register
// the back end takes a new request only after finishing the last one, set by
//   each stack's memory: the new top comes back through the registered read
//   port before the next command may use it
// the front queue holds two requests, so requests keep being taken while a
//   response waits; req_stall rises only when the queue is full
// a stalled response holds its value; the back end stops after finishing
//   the next command until the response register is free
// reset empties the queue and clears both counts and ring bases; the stack
//   memories are not cleared and no request is refused after reset
// ----------------------------------------------------------------------------
module dual_stack_rotate_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dsr_pkg::cmd_t  cmd,
  input  dsr_pkg::word_t load_value,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dsr_pkg::word_t top_a,
  output dsr_pkg::word_t top_b,
  output dsr_pkg::cnt_t  count_a,
  output dsr_pkg::cnt_t  count_b,
  output logic           fault
);
  import dsr_pkg::*;

  logic q_valid;
  logic q_pop;
  dec_t q_head;

  dsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .load_value (load_value),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  dsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .top_a     (top_a),
    .top_b     (top_b),
    .count_a   (count_a),
    .count_b   (count_b),
    .fault     (fault)
  );

  a_fault_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fault |-> (count_a == cnt_t'(DEPTH)) || (count_b == cnt_t'(DEPTH)))
    else $error("fault reported with neither stack full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (count_a <= cnt_t'(DEPTH)) && (count_b <= cnt_t'(DEPTH)))
    else $error("stack count beyond depth");

  a_empty_a: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (count_a == '0) |-> (top_a == '0))
    else $error("empty stack a reports nonzero top");

  a_empty_b: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (count_b == '0) |-> (top_b == '0))
    else $error("empty stack b reports nonzero top");

endmodule

// File: src/dsr_front.sv
// ----------------------------------------------------------------------------
// dsr_front
// takes requests, decodes each command into one operation per stack and
// holds the decoded requests in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module dsr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dsr_pkg::cmd_t  cmd,
  input  dsr_pkg::word_t load_value,
  output logic           q_valid,
  output dsr_pkg::dec_t  q_head,
  input  logic           q_pop
);
  import dsr_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  dec_t              dec;
  dec_t              q [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;
  logic              accept;

  always_comb begin
    dec       = '0;
    dec.value = load_value;
    case (cmd)
      CMD_LOAD:  dec.op_a = SOP_PUSH;
      CMD_SA:    dec.op_a = SOP_SWAP;
      CMD_SB:    dec.op_b = SOP_SWAP;
      CMD_SS: begin
        dec.op_a = SOP_SWAP;
        dec.op_b = SOP_SWAP;
      end
      CMD_PA: begin
        dec.op_a = SOP_PUSH;
        dec.op_b = SOP_POP;
        dec.move = 1'b1;
      end
      CMD_PB: begin
        dec.op_a = SOP_POP;
        dec.op_b = SOP_PUSH;
        dec.move = 1'b1;
      end
      CMD_RA:    dec.op_a = SOP_ROT;
      CMD_RB:    dec.op_b = SOP_ROT;
      CMD_RR: begin
        dec.op_a = SOP_ROT;
        dec.op_b = SOP_ROT;
      end
      CMD_RRA:   dec.op_a = SOP_RROT;
      CMD_RRB:   dec.op_b = SOP_RROT;
      CMD_RRR: begin
        dec.op_a = SOP_RROT;
        dec.op_b = SOP_RROT;
      end
      CMD_CLEAR: begin
        dec.op_a = SOP_CLEAR;
        dec.op_b = SOP_CLEAR;
      end
      default:   dec.op_a = SOP_NONE;
    endcase
  end

  assign req_stall = (cnt == QCNT_W'(QDEPTH));
  assign accept    = req_valid && !req_stall;
  assign q_valid   = (cnt != '0);
  assign q_head    = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wp <= wp + QPTR_W'(1);
      end
      if (q_pop) begin
        rp <= rp + QPTR_W'(1);
      end
      if (accept && !q_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (q_pop && !accept) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= dec;
    end
  end

endmodule

// File: src/dsr_stack.sv
// ----------------------------------------------------------------------------
// dsr_stack
// one bounded ring stack: top item cached in a register, the rest in a
// single-port-write, single-port-read memory with registered read data
// ----------------------------------------------------------------------------
module dsr_stack (
  input  logic              clk,
  input  logic              rst,
  input  dsr_pkg::stk_ctl_t ctl,
  input  dsr_pkg::word_t    push_value,
  output dsr_pkg::word_t    top,
  output dsr_pkg::cnt_t     fill
);
  import dsr_pkg::*;

  word_t mem [DEPTH];
  word_t rdata;
  word_t top_r;
  cnt_t  fill_r;
  cnt_t  fill_next;
  addr_t base_r;
  addr_t base_next;
  logic  pend;
  logic  pend_next;
  logic  top_push;
  logic  we;
  logic  re;
  addr_t waddr;
  addr_t raddr;
  cnt_t  fm1;
  cnt_t  fm2;
  addr_t k1;
  addr_t k2;
  addr_t base_dn;
  addr_t base_up;
  logic  two;

  assign fm1     = fill_r - cnt_t'(1);
  assign fm2     = fill_r - cnt_t'(2);
  assign k1      = fm1[ADDR_W-1:0];
  assign k2      = fm2[ADDR_W-1:0];
  assign two     = (fill_r >= cnt_t'(2));
  assign base_dn = (base_r == '0) ? addr_t'(DEPTH - 1) : base_r - addr_t'(1);
  assign base_up = (base_r == addr_t'(DEPTH - 1)) ? '0 : base_r + addr_t'(1);

  always_comb begin
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = '0;
    fill_next = fill_r;
    base_next = base_r;
    top_push  = 1'b0;
    pend_next = ctl.fin ? 1'b0 : pend;
    if (ctl.go) begin
      case (ctl.op)
        SOP_PUSH: begin
          we        = (fill_r != '0);
          waddr     = slot_of(base_r, k1);
          top_push  = 1'b1;
          fill_next = fill_r + cnt_t'(1);
        end
        SOP_POP: begin
          fill_next = fm1;
          if (two) begin
            re        = 1'b1;
            raddr     = slot_of(base_r, k2);
            pend_next = 1'b1;
          end
        end
        SOP_SWAP: begin
          if (two) begin
            re        = 1'b1;
            raddr     = slot_of(base_r, k2);
            we        = 1'b1;
            waddr     = slot_of(base_r, k2);
            pend_next = 1'b1;
          end
        end
        SOP_ROT: begin
          if (two) begin
            re        = 1'b1;
            raddr     = slot_of(base_r, k2);
            we        = 1'b1;
            waddr     = base_dn;
            base_next = base_dn;
            pend_next = 1'b1;
          end
        end
        SOP_RROT: begin
          if (two) begin
            re        = 1'b1;
            raddr     = base_r;
            we        = 1'b1;
            waddr     = slot_of(base_r, k1);
            base_next = base_up;
            pend_next = 1'b1;
          end
        end
        SOP_CLEAR: begin
          fill_next = '0;
          base_next = '0;
        end
        default: begin
          fill_next = fill_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_r <= '0;
      base_r <= '0;
      pend   <= 1'b0;
    end else begin
      fill_r <= fill_next;
      base_r <= base_next;
      pend   <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (top_push) begin
      top_r <= push_value;
    end else if (ctl.fin && pend) begin
      top_r <= rdata;
    end
  end

  // read-first: a swap reads and overwrites the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= top_r;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign top  = pend ? rdata : top_r;
  assign fill = fill_r;

endmodule

// File: src/dsr_back.sv
// ----------------------------------------------------------------------------
// dsr_back
// carries out queued requests on the two stacks: checks full and empty
// conditions, sequences the stack units and holds the result register
// ----------------------------------------------------------------------------
module dsr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  dsr_pkg::dec_t  q_head,
  output logic           q_pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dsr_pkg::word_t top_a,
  output dsr_pkg::word_t top_b,
  output dsr_pkg::cnt_t  count_a,
  output dsr_pkg::cnt_t  count_b,
  output logic           fault
);
  import dsr_pkg::*;

  typedef enum logic {S_RUN, S_FIN} state_t;

  state_t   st;
  stk_ctl_t ctl_a;
  stk_ctl_t ctl_b;
  stk_op_t  eff_a;
  stk_op_t  eff_b;
  word_t    s_top_a;
  word_t    s_top_b;
  cnt_t     s_fill_a;
  cnt_t     s_fill_b;
  logic     full_a;
  logic     full_b;
  logic     src_a;
  logic     src_b;
  logic     ok_a;
  logic     ok_b;
  logic     fault_now;
  logic     fault_r;
  logic     go;
  logic     fin;
  logic     out_free;
  logic     capture;

  assign full_a = (s_fill_a == cnt_t'(DEPTH));
  assign full_b = (s_fill_b == cnt_t'(DEPTH));
  // a move needs something on the other stack
  assign src_a  = !q_head.move || (s_fill_b != '0);
  assign src_b  = !q_head.move || (s_fill_a != '0);
  assign ok_a   = !full_a && src_a;
  assign ok_b   = !full_b && src_b;

  always_comb begin
    eff_a = q_head.op_a;
    eff_b = q_head.op_b;
    case (q_head.op_a)
      SOP_PUSH: eff_a = ok_a ? SOP_PUSH : SOP_NONE;
      SOP_POP:  eff_a = ok_b ? SOP_POP  : SOP_NONE;
      default:  eff_a = q_head.op_a;
    endcase
    case (q_head.op_b)
      SOP_PUSH: eff_b = ok_b ? SOP_PUSH : SOP_NONE;
      SOP_POP:  eff_b = ok_a ? SOP_POP  : SOP_NONE;
      default:  eff_b = q_head.op_b;
    endcase
  end

  assign fault_now = ((q_head.op_a == SOP_PUSH) && full_a && src_a) ||
                     ((q_head.op_b == SOP_PUSH) && full_b && src_b);

  assign go       = (st == S_RUN) && q_valid;
  assign fin      = (st == S_FIN);
  assign q_pop    = go;
  assign out_free = !rsp_valid || !rsp_stall;
  assign capture  = fin && out_free;

  assign ctl_a = '{go: go, fin: fin, op: eff_a};
  assign ctl_b = '{go: go, fin: fin, op: eff_b};

  dsr_stack u_stack_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_a),
    .push_value (q_head.move ? s_top_b : q_head.value),
    .top        (s_top_a),
    .fill       (s_fill_a)
  );

  dsr_stack u_stack_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_b),
    .push_value (s_top_a),
    .top        (s_top_b),
    .fill       (s_fill_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_RUN;
      rsp_valid <= 1'b0;
    end else begin
      case (st)
        S_RUN:   if (go) st <= S_FIN;
        S_FIN:   if (out_free) st <= S_RUN;
        default: st <= S_RUN;
      endcase
      if (capture) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (go) begin
      fault_r <= fault_now;
    end
    if (capture) begin
      top_a   <= (s_fill_a == '0) ? '0 : s_top_a;
      top_b   <= (s_fill_b == '0) ? '0 : s_top_b;
      count_a <= s_fill_a;
      count_b <= s_fill_b;
      fault   <= fault_r;
    end
  end

endmodule
